### sv/idiv_pkg.sv
// shared types and constants for the 64-bit integer divider
package idiv_pkg;

    localparam int XLEN   = 64;
    localparam int SIGN_B = XLEN - 1;
    localparam int CNT_W  = $clog2(XLEN);

    typedef logic [XLEN-1:0]  t_word;
    typedef logic [CNT_W-1:0] t_cnt;

    // operation codes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam t_cnt LAST_STEP = t_cnt'(XLEN - 1);

    // status of the iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    // two's complement negation
    function automatic t_word neg_word(input t_word v);
        neg_word = (~v) + t_word'(1);
    endfunction

endpackage

### sv/idiv_core.sv
// iterative restoring divide unit, one quotient bit per cycle
module idiv_core
    import idiv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_word      i_num,
    input  t_word      i_den,
    output t_core_stat o_stat,
    output t_word      o_quo,
    output t_word      o_rem
);

    logic  r_busy;
    logic  r_done;
    t_cnt  r_cnt;
    t_word r_part;
    t_word r_num;
    t_word r_den;

    logic         carry;
    t_word        shifted;
    logic [XLEN:0] diff;
    logic         take;
    t_word        n_part;

    // shared compare/subtract step
    always_comb begin
        carry   = r_part[SIGN_B];
        shifted = {r_part[SIGN_B-1:0], r_num[SIGN_B]};
        diff    = {carry, shifted} - {1'b0, r_den};
        take    = ~diff[XLEN];
        n_part  = take ? diff[XLEN-1:0] : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + t_cnt'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_part <= '0;
            r_num  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_part <= n_part;
            // quotient bits enter at the bottom as dividend bits leave the top
            r_num  <= {r_num[SIGN_B-1:0], take};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_num;
    assign o_rem       = r_part;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("start while busy");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_cnt) == LAST_STEP)
        else $error("done without final step");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done longer than one cycle");

endmodule

### sv/int64_divider_signed_unsigned.sv
// top level of the 64-bit signed/unsigned integer divider
// usage:
//   input channel: i_valid with i_opcode, i_dividend, i_divisor; the block drives o_stall.
//   a transfer happens on a rising edge with i_valid high and o_stall low.
//   i_opcode low divides unsigned words, high divides two's complement words.
//   output channel: o_valid with o_quotient, o_remainder; the receiver drives i_stall.
//   an item passes through 64 restoring steps in the divide unit, is handed
//   to the sequencer's done state and gets its sign fix-up on the way into the
//   output register. one item is in flight at a time: the single shared subtract
//   unit makes one quotient bit per cycle, and o_stall is high from the
//   input transfer until the result is written to the output register.
//   the output register lets a new item enter while the previous result waits.
//   a zero divisor gives zero quotient and remainder in both modes; the most
//   negative dividend over minus one wraps the quotient to the most negative value.
//   if the receiver stalls, the result holds in the output register and a finished
//   item waits in the divide unit until the register frees up.
//   reset (i_rst_n low, synchronous) empties the block: no result pending, ready.
module int64_divider_signed_unsigned
    import idiv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  logic  i_opcode,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output logic  o_valid,
    input  logic  i_stall,
    output t_word o_quotient,
    output t_word o_remainder
);

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_neg_q;
    logic       r_neg_r;
    logic       r_zero;
    logic       r_out_valid;
    t_word      r_quotient;
    t_word      r_remainder;

    logic       in_xfer;
    logic       out_free;
    logic       load_out;
    logic       a_neg;
    logic       b_neg;
    t_word      num_mag;
    t_word      den_mag;
    t_word      core_quo;
    t_word      core_rem;
    t_core_stat core_stat;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign load_out = (r_state == S_DONE) && out_free;

    // magnitudes of the operands in signed mode
    always_comb begin
        a_neg   = (i_opcode == OP_SIGNED) && i_dividend[SIGN_B];
        b_neg   = (i_opcode == OP_SIGNED) && i_divisor[SIGN_B];
        num_mag = a_neg ? neg_word(i_dividend) : i_dividend;
        den_mag = b_neg ? neg_word(i_divisor) : i_divisor;
    end

    idiv_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_stat  (core_stat),
        .o_quo   (core_quo),
        .o_rem   (core_rem)
    );

    // sequencer: idle -> run (64 steps) -> done (wait for the output register)
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) begin
                n_state = S_RUN;
            end
            S_RUN: if (core_stat.done) begin
                n_state = S_DONE;
            end
            S_DONE: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sign and zero-divisor flags travel with the item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_neg_q <= a_neg ^ b_neg;
            r_neg_r <= a_neg;
            r_zero  <= (i_divisor == '0);
        end
    end

    // sign fix-up into the output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_zero) begin
                r_quotient  <= '0;
                r_remainder <= '0;
            end else begin
                r_quotient  <= r_neg_q ? neg_word(core_quo) : core_quo;
                r_remainder <= r_neg_r ? neg_word(core_rem) : core_rem;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;

    a_xfer_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_RUN) && core_stat.busy)
        else $error("accepted item did not start the divide unit");
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.done |-> (r_state == S_RUN))
        else $error("divide unit finished outside run state");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !core_stat.busy && !core_stat.done)
        else $error("divide unit active while idle");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_valid)
        else $error("result load lost");

endmodule
